>>> hw/rtl/sse_pkg.sv
// shared types and constants of the selection sort engine
package sse_pkg;

    localparam int unsigned DATA_W = 32;

    // configuration register indexes
    localparam logic REG_SORT_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_POS_RD,
        S_POS_DAT,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_OUT_RD,
        S_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic wr_item;
        logic close;
        logic pos_rd;
        logic pos_dat;
        logic scan_cmp;
        logic swap_a;
        logic swap_b;
        logic out_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pos_ok;
        logic scan_done;
        logic out_last;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/sse_datapath.sv
// element store, sort indexes, minimum search and output register
module sse_datapath #(
    parameter int unsigned MAX_ELEMENTS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sse_pkg::t_cmd                      i_cmd,
    output sse_pkg::t_status                   o_status,
    input  logic signed [sse_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic signed [sse_pkg::DATA_W-1:0]  o_value_res,
    output logic                               o_last_res
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    logic signed [sse_pkg::DATA_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [sse_pkg::DATA_W-1:0] r_rd_data;

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_scan, n_scan;
    logic [AW-1:0] r_best, n_best;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic [AW-1:0] r_oidx, n_oidx;
    logic signed [sse_pkg::DATA_W-1:0] r_posval, n_posval;
    logic signed [sse_pkg::DATA_W-1:0] r_bestval, n_bestval;
    logic r_valid, n_valid;
    logic signed [sse_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic r_out_last, n_out_last;

    logic                              full;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [sse_pkg::DATA_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;

    assign full = (r_count == CW'(MAX_ELEMENTS));

    assign o_status.pos_ok    = ((CW'(r_pos) + CW'(1)) < r_count);
    assign o_status.scan_done = (r_scan == r_count);
    assign o_status.out_last  = ((CW'(r_oidx) + CW'(1)) == r_count);
    assign o_status.out_free  = !r_valid || !i_stall;

    // store write and read port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = i_value;
        rd_en   = 1'b0;
        rd_addr = r_pos;
        if (i_cmd.wr_item && !full) begin
            wr_en = 1'b1;
        end
        if (i_cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = r_best;
            wr_data = r_posval;
        end
        if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            wr_data = r_bestval;
        end
        if (i_cmd.pos_rd) begin
            rd_en = 1'b1;
        end
        if (i_cmd.pos_dat || (i_cmd.scan_cmp && !o_status.scan_done)) begin
            rd_en   = 1'b1;
            rd_addr = r_scan[AW-1:0];
        end
        if (i_cmd.out_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_oidx;
        end
        if (i_cmd.out_load && !o_status.out_last) begin
            rd_en   = 1'b1;
            rd_addr = r_oidx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_best      = r_best;
        n_cmp_idx   = r_cmp_idx;
        n_oidx      = r_oidx;
        n_posval    = r_posval;
        n_bestval   = r_bestval;
        n_valid     = r_valid && i_stall;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        if (i_cmd.wr_item && !full) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.close) begin
            n_pos  = '0;
            n_oidx = '0;
        end
        if (i_cmd.pos_rd) begin
            n_scan = CW'(r_pos) + CW'(1);
        end
        if (i_cmd.pos_dat) begin
            n_posval  = r_rd_data;
            n_bestval = r_rd_data;
            n_best    = r_pos;
            n_cmp_idx = r_scan[AW-1:0];
            n_scan    = r_scan + CW'(1);
        end
        if (i_cmd.scan_cmp) begin
            // strict less-than keeps the first smallest
            if (r_rd_data < r_bestval) begin
                n_bestval = r_rd_data;
                n_best    = r_cmp_idx;
            end
            if (!o_status.scan_done) begin
                n_cmp_idx = r_scan[AW-1:0];
                n_scan    = r_scan + CW'(1);
            end
        end
        if (i_cmd.swap_b) begin
            n_pos = r_pos + AW'(1);
        end
        if (i_cmd.out_load) begin
            n_valid     = 1'b1;
            n_out_value = r_rd_data;
            n_out_last  = o_status.out_last;
            if (o_status.out_last) begin
                n_count = '0;
            end else begin
                n_oidx = r_oidx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_pos       <= n_pos;
        r_scan      <= n_scan;
        r_best      <= n_best;
        r_cmp_idx   <= n_cmp_idx;
        r_oidx      <= n_oidx;
        r_posval    <= n_posval;
        r_bestval   <= n_bestval;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid     = r_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;

endmodule

>>> hw/rtl/sse_ctrl.sv
// sequencer for load, selection sort passes and emit
module sse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    input  logic             i_sort_enable,
    input  sse_pkg::t_status i_status,
    output sse_pkg::t_cmd    o_cmd,
    output logic             o_stall
);

    sse_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            sse_pkg::S_LOAD: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.wr_item = 1'b1;
                    if (i_last) begin
                        o_cmd.close = 1'b1;
                        n_state = i_sort_enable ? sse_pkg::S_POS_RD : sse_pkg::S_OUT_RD;
                    end
                end
            end
            sse_pkg::S_POS_RD: begin
                if (i_status.pos_ok) begin
                    o_cmd.pos_rd = 1'b1;
                    n_state = sse_pkg::S_POS_DAT;
                end else begin
                    n_state = sse_pkg::S_OUT_RD;
                end
            end
            sse_pkg::S_POS_DAT: begin
                o_cmd.pos_dat = 1'b1;
                n_state = sse_pkg::S_SCAN;
            end
            sse_pkg::S_SCAN: begin
                o_cmd.scan_cmp = 1'b1;
                if (i_status.scan_done) begin
                    n_state = sse_pkg::S_SWAP_A;
                end
            end
            sse_pkg::S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state = sse_pkg::S_SWAP_B;
            end
            sse_pkg::S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state = sse_pkg::S_POS_RD;
            end
            sse_pkg::S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = sse_pkg::S_OUT_EMIT;
            end
            sse_pkg::S_OUT_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.out_last) begin
                        n_state = sse_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = sse_pkg::S_LOAD;
            end
        endcase
    end

endmodule

>>> hw/rtl/selection_sort_engine_core.sv
// top level of the selection sort engine: config register, sequencer and datapath
//
// usage
// - input channel (i_valid, o_stall, i_value, i_last): one signed value per item;
//   the item with i_last high closes the set. items beyond MAX_ELEMENTS are
//   dropped, but a dropped item with i_last still closes the set
// - output channel (o_valid, i_stall, o_value_res, o_last_res): the set comes
//   back one item per element, ascending when sort_enable is set, else in load
//   order; o_last_res marks the final element
// - config: sort_enable at byte address 0, written over the apb port
// data flow
// - loading takes one item per cycle; o_stall is high from the closing item
//   until the last element has been handed to the output register
// - sorting n elements runs n-1 passes of one shared comparator over a store
//   with one read port and one write port
// - emit streams one element per cycle from the store read port while the
//   receiver does not stall, after a first read that primes the port
// - a stalling receiver holds the output register and pauses the emit
// reset clears the element count, the output valid flag and the sequencer, and
// sets sort_enable; the store contents are left as they are
module selection_sort_engine_core #(
    parameter int unsigned MAX_ELEMENTS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sse_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_last,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [sse_pkg::DATA_W-1:0]  o_value_res,
    output logic                               o_last_res,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic             r_sort_enable;
    logic             cfg_wr;
    sse_pkg::t_cmd    cmd;
    sse_pkg::t_status status;

    // register index is the word address; the byte lane bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == sse_pkg::REG_SORT_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_sort_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == sse_pkg::REG_SORT_ENABLE) ? {31'b0, r_sort_enable} : 32'b0;

    // sequencer: load, sort passes, emit
    sse_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last        (i_last),
        .i_sort_enable (r_sort_enable),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_stall       (o_stall)
    );

    // store, comparator and output register
    sse_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

endmodule
